// ----- design/sofd_pkg.sv -----
// ----------------------------------------------------------------------------
// sofd_pkg
// Shared types and constants for the start-of-frame / length / XOR deframer.
// ----------------------------------------------------------------------------
package sofd_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_START_BYTE  = 8'h01;
    localparam logic [BYTE_W-1:0] RST_ACK_BYTE    = 8'h06;
    localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD = 8'hFE;

    // checksum seed
    localparam logic [BYTE_W-1:0] XOR_SEED = 8'hFF;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME_OK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CSUM_ERR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FRAME_ERR = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CHECK = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] ack_byte;
        logic [BYTE_W-1:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              last_payload;
        logic [BYTE_W-1:0] payload_count;
    } t_result;

endpackage

// ----- design/sof_length_xor_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// sof_length_xor_frame_deframer
// Start-of-frame / length / XOR-checksum receive deframer.
// ----------------------------------------------------------------------------
// Takes one received byte per item. While hunting, acknowledge bytes are
// dropped, the start byte opens a frame and any other byte gives a framing
// error. The byte after the start byte is the length (payload plus checksum);
// zero, or a payload above max_payload, gives a framing error and the block
// hunts again. Payload bytes come out one per item with index, last mark and
// frame payload count. A running XOR seeded with 0xFF over the length and
// payload is compared with the final byte: match gives "frame good, send
// acknowledge", mismatch a checksum error. Acknowledge and start values
// inside a frame are ordinary bytes. Throughput is one item per clock while
// the result side is not stalled; an item passes the input register, then the
// phase machine into the result register, where its result waits under
// back-pressure. Items causing no result (acknowledge, start, a good length
// byte) leave the output untouched.
// Configuration is sampled live, so write it only while the block is idle.
// ----------------------------------------------------------------------------
module sof_length_xor_frame_deframer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [sofd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sofd_pkg::BYTE_W-1:0]      i_cfg_data,
    // received byte channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [sofd_pkg::BYTE_W-1:0]      i_rx_byte,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sofd_pkg::KIND_W-1:0]      o_result_kind,
    output logic [sofd_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [sofd_pkg::BYTE_W-1:0]      o_byte_index,
    output logic                             o_last_payload,
    output logic [sofd_pkg::BYTE_W-1:0]      o_payload_count
);

    sofd_pkg::t_cfg              cfg;
    sofd_pkg::t_result           result;
    logic                        item_valid;
    logic [sofd_pkg::BYTE_W-1:0] item_byte;
    logic                        take;

    sofd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register: decouples upstream from the result side
    sofd_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_take       (take),
        .o_item_valid (item_valid),
        .o_item_byte  (item_byte)
    );

    // phase machine, checksum and result register
    sofd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .i_item_byte  (item_byte),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_result_kind   = result.result_kind;
    assign o_data_byte     = result.data_byte;
    assign o_byte_index    = result.byte_index;
    assign o_last_payload  = result.last_payload;
    assign o_payload_count = result.payload_count;

endmodule

// ----- design/sofd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sofd_cfg_regs
// Configuration register file: start byte, acknowledge byte, payload limit.
// ----------------------------------------------------------------------------
module sofd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sofd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sofd_pkg::BYTE_W-1:0]      i_cfg_data,
    output sofd_pkg::t_cfg                   o_cfg
);

    sofd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= sofd_pkg::RST_START_BYTE;
            r_cfg.ack_byte    <= sofd_pkg::RST_ACK_BYTE;
            r_cfg.max_payload <= sofd_pkg::RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sofd_pkg::CFG_START_BYTE:  r_cfg.start_byte  <= i_cfg_data;
                sofd_pkg::CFG_ACK_BYTE:    r_cfg.ack_byte    <= i_cfg_data;
                sofd_pkg::CFG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/sofd_in_stage.sv -----
// ----------------------------------------------------------------------------
// sofd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module sofd_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [sofd_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_take,
    output logic                        o_item_valid,
    output logic [sofd_pkg::BYTE_W-1:0] o_item_byte
);

    logic                        r_valid;
    logic [sofd_pkg::BYTE_W-1:0] r_byte;
    logic                        load;

    assign o_in_ready = !r_valid || i_take;
    assign load       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item_byte  = r_byte;

endmodule

// ----- design/sofd_parser.sv -----
// ----------------------------------------------------------------------------
// sofd_parser
// Frame phase machine, length/checksum tracking and the result register.
// ----------------------------------------------------------------------------
module sofd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sofd_pkg::t_cfg              i_cfg,
    input  logic                        i_item_valid,
    input  logic [sofd_pkg::BYTE_W-1:0] i_item_byte,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sofd_pkg::t_result           o_result
);

    sofd_pkg::t_phase            r_phase,  n_phase;
    logic [sofd_pkg::BYTE_W-1:0] r_len,    n_len;
    logic [sofd_pkg::BYTE_W-1:0] r_seen,   n_seen;
    logic [sofd_pkg::BYTE_W-1:0] r_xor,    n_xor;
    logic                        r_out_valid;
    sofd_pkg::t_result           r_result, n_result;
    logic                        has_result;

    logic [sofd_pkg::BYTE_W-1:0] b;
    logic [sofd_pkg::BYTE_W-1:0] payload;
    logic [sofd_pkg::BYTE_W:0]   seen_inc;
    logic                        is_last;

    assign b        = i_item_byte;
    assign payload  = b - 8'd1;
    assign seen_inc = {1'b0, r_seen} + 9'd1;
    assign is_last  = seen_inc >= {1'b0, r_len};

    // result slot free, or being emptied this cycle
    assign o_take = i_item_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_seen     = r_seen;
        n_xor      = r_xor;
        has_result = 1'b0;
        n_result   = '{result_kind:   sofd_pkg::KIND_FRAME_ERR,
                       data_byte:     b,
                       byte_index:    '0,
                       last_payload:  1'b0,
                       payload_count: '0};

        unique case (r_phase)
            sofd_pkg::PH_HUNT: begin
                if (b == i_cfg.ack_byte) begin
                    // acknowledge dropped quietly
                end else if (b == i_cfg.start_byte) begin
                    n_phase = sofd_pkg::PH_LEN;
                    n_xor   = sofd_pkg::XOR_SEED;
                end else begin
                    has_result = 1'b1;
                end
            end
            sofd_pkg::PH_LEN: begin
                if (b == '0 || payload > i_cfg.max_payload) begin
                    has_result = 1'b1;
                    n_phase    = sofd_pkg::PH_HUNT;
                    n_len      = '0;
                    n_seen     = '0;
                    n_xor      = sofd_pkg::XOR_SEED;
                end else begin
                    n_xor   = sofd_pkg::XOR_SEED ^ b;
                    n_len   = payload;
                    n_seen  = '0;
                    n_phase = (payload == '0) ? sofd_pkg::PH_CHECK : sofd_pkg::PH_DATA;
                end
            end
            sofd_pkg::PH_DATA: begin
                has_result             = 1'b1;
                n_xor                  = r_xor ^ b;
                n_seen                 = seen_inc[sofd_pkg::BYTE_W-1:0];
                n_result.result_kind   = sofd_pkg::KIND_PAYLOAD;
                n_result.byte_index    = r_seen;
                n_result.last_payload  = is_last;
                n_result.payload_count = r_len;
                if (is_last) begin
                    n_phase = sofd_pkg::PH_CHECK;
                end
            end
            sofd_pkg::PH_CHECK: begin
                has_result             = 1'b1;
                n_result.result_kind   = (b == r_xor) ? sofd_pkg::KIND_FRAME_OK
                                                      : sofd_pkg::KIND_CSUM_ERR;
                n_result.payload_count = r_len;
                n_phase                = sofd_pkg::PH_HUNT;
                n_len                  = '0;
                n_seen                 = '0;
                n_xor                  = sofd_pkg::XOR_SEED;
            end
            default: begin
                n_phase = sofd_pkg::PH_HUNT;
                n_len   = '0;
                n_seen  = '0;
                n_xor   = sofd_pkg::XOR_SEED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sofd_pkg::PH_HUNT;
            r_len       <= '0;
            r_seen      <= '0;
            r_xor       <= sofd_pkg::XOR_SEED;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase     <= n_phase;
                r_len       <= n_len;
                r_seen      <= n_seen;
                r_xor       <= n_xor;
                r_out_valid <= has_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && has_result) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

`ifndef SYNTHESIS
    a_seen_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sofd_pkg::PH_DATA) |-> (r_seen < r_len))
        else $error("payload counter ran past frame length");

    a_last_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_phase == sofd_pkg::PH_DATA && is_last)
            |=> (r_phase == sofd_pkg::PH_CHECK))
        else $error("last payload item did not lead to checksum phase");

    a_check_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_phase == sofd_pkg::PH_CHECK)
            |=> (r_phase == sofd_pkg::PH_HUNT && r_xor == sofd_pkg::XOR_SEED
                 && r_out_valid))
        else $error("checksum item did not give a result and return to hunting");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_result)))
        else $error("pending result lost or changed under back-pressure");
`endif

endmodule
